// ----- sv/mrmi_pkg.sv -----
// Shared types and constants for the memory range map insert block.
// Depends on nothing; every other file but mrmi_ram imports it.
package mrmi_pkg;

   localparam int TYPE_W   = 4;
   localparam int PAGE_W   = 52;
   localparam int CNT_W    = 53;
   localparam int ATTR_W   = 64;
   localparam int ADDR_W   = 64;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // piece walk steps within one table entry
   localparam logic [1:0] SUB_LEFT  = 2'd0;
   localparam logic [1:0] SUB_RIGHT = 2'd1;
   localparam logic [1:0] SUB_DONE  = 2'd2;

   typedef struct packed {
      logic [TYPE_W-1:0] mtype;
      logic [PAGE_W-1:0] start_page;
      logic [CNT_W-1:0]  pages;
      logic [ATTR_W-1:0] attr;
   } region_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_P1_RD,
      ST_P1_EV,
      ST_P2_START,
      ST_P2_RD,
      ST_P2_EV,
      ST_P2_TAIL,
      ST_COMMIT,
      ST_OUT_START,
      ST_OUT_RD,
      ST_OUT_SHOW,
      ST_OUT_EMPTY
   } state_type;

   typedef struct packed {
      logic capture;
      logic idx_clr;
      logic idx_inc;
      logic rd;
      logic count_piece;
      logic emit;
      logic emit_tail;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic is_invalid;
      logic idx_at_end;
      logic entry_done;
      logic count_zero;
      logic out_last;
   } stat_type;

endpackage

// ----- sv/mrmi_if.sv -----
// Request and response channel interfaces (valid/ready handshake).
// Depends on mrmi_pkg.
interface mrmi_req_if;
   import mrmi_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [TYPE_W-1:0]   mem_type;
   logic [ADDR_W-1:0]   range_start;
   logic [ADDR_W-1:0]   range_end;
   logic [ATTR_W-1:0]   attributes;

   modport source (output valid, req_type, mem_type, range_start, range_end, attributes,
                   input ready);
   modport sink   (input valid, req_type, mem_type, range_start, range_end, attributes,
                   output ready);
endinterface

interface mrmi_rsp_if;
   import mrmi_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                has_entry;
   logic [INDEX_W-1:0]  entry_index;
   logic [TYPE_W-1:0]   entry_type;
   logic [PAGE_W-1:0]   entry_start_page;
   logic [CNT_W-1:0]    entry_page_count;
   logic [ATTR_W-1:0]   entry_attr;
   logic                last;

   modport source (output valid, status, has_entry, entry_index, entry_type, entry_start_page,
                   entry_page_count, entry_attr, last, input ready);
   modport sink   (input valid, status, has_entry, entry_index, entry_type, entry_start_page,
                   entry_page_count, entry_attr, last, output ready);
endinterface

// ----- sv/memory_range_map_insert.sv -----
// Memory range map insert: top level joining the sequencer and the datapath.
// An insert makes a count pass over the entries held, then a rebuild pass into the other table
// that adds the new entry, then gives out one result per table entry (one result when empty).
// One request is taken at a time, with output stalls holding it; clear and empty ranges
// go straight to the readout. Reset empties the table; region storage itself is not cleared.
// Depends on mrmi_pkg, mrmi_if, mrmi_ctrl, mrmi_dp.
module memory_range_map_insert #(
   parameter int MAX_ENTRIES = 64,
   parameter int PAGE_SHIFT  = 12
) (
   input logic        clock,
   input logic        reset,
   mrmi_req_if.sink   req_chan,
   mrmi_rsp_if.source rsp_chan
);
   import mrmi_pkg::*;

   cmd_type  cmd;
   stat_type st;

   mrmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   mrmi_dp #(.MAX_ENTRIES(MAX_ENTRIES), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .in_req_type          (req_chan.req_type),
      .in_mem_type          (req_chan.mem_type),
      .in_range_start       (req_chan.range_start),
      .in_range_end         (req_chan.range_end),
      .in_attributes        (req_chan.attributes),
      .out_status           (rsp_chan.status),
      .out_has_entry        (rsp_chan.has_entry),
      .out_entry_index      (rsp_chan.entry_index),
      .out_entry_type       (rsp_chan.entry_type),
      .out_entry_start_page (rsp_chan.entry_start_page),
      .out_entry_page_count (rsp_chan.entry_page_count),
      .out_entry_attr       (rsp_chan.entry_attr),
      .out_last             (rsp_chan.last)
   );

   // one request in flight: no new request while results are being given out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_chan.valid && req_chan.ready))
      else $error("request taken while response pending");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last |=> req_chan.ready)
      else $error("not ready after final result");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready && !rsp_chan.valid)
      else $error("request not processed before response");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.has_entry |-> rsp_chan.last)
      else $error("empty table result not marked final");
endmodule

// ----- sv/mrmi_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
module mrmi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/mrmi_ctrl.sv -----
// Sequencing state machine: count pass, rebuild pass, table readout.
// Depends on mrmi_pkg.
module mrmi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  mrmi_pkg::stat_type st,
   output mrmi_pkg::cmd_type  cmd
);
   import mrmi_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE:    state_in = (st.is_clear || st.is_invalid) ? ST_OUT_START : ST_P1_RD;
         ST_P1_RD:     state_in = st.idx_at_end ? ST_P2_START : ST_P1_EV;
         ST_P1_EV:     state_in = ST_P1_RD;
         ST_P2_START:  state_in = ST_P2_RD;
         ST_P2_RD:     state_in = st.idx_at_end ? ST_P2_TAIL : ST_P2_EV;
         ST_P2_EV:     if (st.entry_done) state_in = ST_P2_RD;
         ST_P2_TAIL:   state_in = ST_COMMIT;
         ST_COMMIT:    state_in = ST_OUT_START;
         ST_OUT_START: state_in = st.count_zero ? ST_OUT_EMPTY : ST_OUT_RD;
         ST_OUT_RD:    state_in = ST_OUT_SHOW;
         ST_OUT_SHOW:  if (rsp_ready) state_in = st.out_last ? ST_IDLE : ST_OUT_RD;
         ST_OUT_EMPTY: if (rsp_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_P1_RD:     cmd.rd = !st.idx_at_end;
         ST_P1_EV: begin
            cmd.count_piece = 1'b1;
            cmd.idx_inc     = 1'b1;
         end
         ST_P2_START:  cmd.idx_clr = 1'b1;
         ST_P2_RD:     cmd.rd = !st.idx_at_end;
         ST_P2_EV: begin
            cmd.emit    = !st.entry_done;
            cmd.idx_inc = st.entry_done;
         end
         ST_P2_TAIL:   cmd.emit_tail = 1'b1;
         ST_COMMIT:    cmd.commit = 1'b1;
         ST_OUT_START: cmd.idx_clr = 1'b1;
         ST_OUT_RD:    cmd.rd = 1'b1;
         ST_OUT_SHOW: begin
            rsp_valid   = 1'b1;
            cmd.idx_inc = rsp_ready;
         end
         ST_OUT_EMPTY: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

// ----- sv/mrmi_dp.sv -----
// Datapath: request registers, ping-pong region tables, piece split and insert.
// Depends on mrmi_pkg and mrmi_ram.
module mrmi_dp #(
   parameter int MAX_ENTRIES = 64,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mrmi_pkg::cmd_type               cmd,
   output mrmi_pkg::stat_type              st,
   input  logic                            in_req_type,
   input  logic [mrmi_pkg::TYPE_W-1:0]     in_mem_type,
   input  logic [mrmi_pkg::ADDR_W-1:0]     in_range_start,
   input  logic [mrmi_pkg::ADDR_W-1:0]     in_range_end,
   input  logic [mrmi_pkg::ATTR_W-1:0]     in_attributes,
   output logic [mrmi_pkg::STATUS_W-1:0]   out_status,
   output logic                            out_has_entry,
   output logic [mrmi_pkg::INDEX_W-1:0]    out_entry_index,
   output logic [mrmi_pkg::TYPE_W-1:0]     out_entry_type,
   output logic [mrmi_pkg::PAGE_W-1:0]     out_entry_start_page,
   output logic [mrmi_pkg::CNT_W-1:0]      out_entry_page_count,
   output logic [mrmi_pkg::ATTR_W-1:0]     out_entry_attr,
   output logic                            out_last
);
   import mrmi_pkg::*;

   localparam int AW  = $clog2(MAX_ENTRIES);
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int PCW = $clog2(MAX_ENTRIES + 2);
   localparam int EW  = CNT_W + 1;  // room for start + pages
   localparam int RW  = $bits(region_type);
   localparam logic [ADDR_W-1:0] LOW_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

   logic [CNT_W-1:0]    s_ff, s_in, e_ff, e_in;
   logic [TYPE_W-1:0]   mtype_ff, mtype_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic                clear_ff, clear_in, invalid_ff, invalid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CW-1:0]       count_ff, count_in, idx_ff, idx_in, wp_ff, wp_in;
   logic [PCW-1:0]      pieces_ff, pieces_in;
   logic                ins_ff, ins_in, bank_ff, bank_in;
   logic [1:0]          sub_ff, sub_in;

   logic [RW-1:0] rd0, rd1;
   region_type    cur, a_piece, b_piece, new_piece, wr_piece, cand;
   logic          wr_en;
   logic [EW-1:0] ds, de, s_x, e_x, cand_start;
   logic          overlap, a_valid, b_raw, b_valid, drop_right, insert_new, cand_valid;
   logic [CW:0]   idx_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         idx_ff    <= '0;
         wp_ff     <= '0;
         pieces_ff <= '0;
         ins_ff    <= 1'b0;
         bank_ff   <= 1'b0;
         sub_ff    <= SUB_DONE;
         status_ff <= STATUS_OK;
         clear_ff  <= 1'b0;
         invalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         wp_ff     <= wp_in;
         pieces_ff <= pieces_in;
         ins_ff    <= ins_in;
         bank_ff   <= bank_in;
         sub_ff    <= sub_in;
         status_ff <= status_in;
         clear_ff  <= clear_in;
         invalid_ff <= invalid_in;
      end
      s_ff     <= s_in;
      e_ff     <= e_in;
      mtype_ff <= mtype_in;
      attr_ff  <= attr_in;
   end

   mrmi_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_ram0 (
      .clock   (clock),
      .wr_en   (wr_en && bank_ff),
      .wr_addr (wp_ff[AW-1:0]),
      .wr_data (wr_piece),
      .rd_en   (cmd.rd && !bank_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd0)
   );

   mrmi_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_ram1 (
      .clock   (clock),
      .wr_en   (wr_en && !bank_ff),
      .wr_addr (wp_ff[AW-1:0]),
      .wr_data (wr_piece),
      .rd_en   (cmd.rd && bank_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd1)
   );

   // piece geometry of the entry just read
   always_comb begin
      cur        = bank_ff ? region_type'(rd1) : region_type'(rd0);
      ds         = EW'(cur.start_page);
      de         = ds + EW'(cur.pages);
      s_x        = EW'(s_ff);
      e_x        = EW'(e_ff);
      overlap    = !(de <= s_x || ds >= e_x);
      a_valid    = !overlap || ds < s_x;
      b_raw      = overlap && de > e_x;
      drop_right = pieces_ff > PCW'(MAX_ENTRIES);
      insert_new = pieces_ff < PCW'(MAX_ENTRIES);
      b_valid    = b_raw && !drop_right;

      a_piece = cur;
      if (overlap) begin
         a_piece.pages = CNT_W'(s_x - ds);
      end
      b_piece            = cur;
      b_piece.start_page = e_ff[PAGE_W-1:0];
      b_piece.pages      = CNT_W'(de - e_x);

      new_piece.mtype      = mtype_ff;
      new_piece.start_page = s_ff[PAGE_W-1:0];
      new_piece.pages      = e_ff - s_ff;
      new_piece.attr       = attr_ff;

      case (sub_ff)
         SUB_LEFT: begin
            cand_valid = a_valid;
            cand       = a_piece;
            cand_start = ds;
         end
         SUB_RIGHT: begin
            cand_valid = b_valid;
            cand       = b_piece;
            cand_start = e_x;
         end
         default: begin
            cand_valid = 1'b0;
            cand       = a_piece;
            cand_start = ds;
         end
      endcase
   end

   always_comb begin
      s_in       = s_ff;
      e_in       = e_ff;
      mtype_in   = mtype_ff;
      attr_in    = attr_ff;
      clear_in   = clear_ff;
      invalid_in = invalid_ff;
      status_in  = status_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      wp_in      = wp_ff;
      pieces_in  = pieces_ff;
      ins_in     = ins_ff;
      bank_in    = bank_ff;
      sub_in     = sub_ff;
      wr_en      = 1'b0;
      wr_piece   = new_piece;

      if (cmd.capture) begin
         s_in       = CNT_W'(in_range_start >> PAGE_SHIFT);
         e_in       = CNT_W'(in_range_end >> PAGE_SHIFT)
                      + CNT_W'((in_range_end & LOW_MASK) != '0);
         mtype_in   = in_mem_type;
         attr_in    = in_attributes;
         clear_in   = in_req_type == REQ_CLEAR;
         invalid_in = in_range_start >= in_range_end;
         if (in_req_type == REQ_CLEAR) begin
            status_in = STATUS_OK;
            count_in  = '0;
         end else begin
            status_in = (in_range_start >= in_range_end) ? STATUS_EMPTY : STATUS_OK;
         end
         idx_in    = '0;
         wp_in     = '0;
         pieces_in = '0;
         ins_in    = 1'b0;
      end
      if (cmd.idx_clr) idx_in = '0;
      if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
      if (cmd.rd)      sub_in = SUB_LEFT;
      if (cmd.count_piece) begin
         pieces_in = pieces_ff + PCW'(a_valid) + PCW'(b_raw);
      end
      if (cmd.emit) begin
         if (cand_valid) begin
            wr_en = 1'b1;
            wp_in = wp_ff + 1'b1;
            // new entry goes ahead of the first piece at or past its start
            if (!ins_ff && insert_new && cand_start >= s_x) begin
               ins_in = 1'b1;
            end else begin
               wr_piece = cand;
               sub_in   = sub_ff + 1'b1;
            end
         end else begin
            sub_in = sub_ff + 1'b1;
         end
      end
      if (cmd.emit_tail && !ins_ff && insert_new) begin
         wr_en  = 1'b1;
         wp_in  = wp_ff + 1'b1;
         ins_in = 1'b1;
      end
      if (cmd.commit) begin
         count_in = wp_ff;
         bank_in  = !bank_ff;
         if (drop_right || !insert_new) status_in = STATUS_FULL;
      end
   end

   assign idx_next = {1'b0, idx_ff} + 1'b1;

   always_comb begin
      st.is_clear   = clear_ff;
      st.is_invalid = invalid_ff;
      st.idx_at_end = idx_ff == count_ff;
      st.entry_done = sub_ff == SUB_DONE;
      st.count_zero = count_ff == '0;
      st.out_last   = idx_next == {1'b0, count_ff};
   end

   always_comb begin
      out_status    = status_ff;
      out_has_entry = !st.count_zero;
      out_last      = st.count_zero || st.out_last;
      if (st.count_zero) begin
         out_entry_index      = '0;
         out_entry_type       = '0;
         out_entry_start_page = '0;
         out_entry_page_count = '0;
         out_entry_attr       = '0;
      end else begin
         out_entry_index      = INDEX_W'(idx_ff);
         out_entry_type       = cur.mtype;
         out_entry_start_page = cur.start_page;
         out_entry_page_count = cur.pages;
         out_entry_attr       = cur.attr;
      end
   end
endmodule

// ----- test/mrmi_tb_if.sv -----
// Testbench copy note: the channel interfaces live with the RTL in mrmi_if.sv.
// Depends on mrmi_pkg; holds the shared request and response records used by the testbench.
package mrmi_tb_pkg;
   import mrmi_pkg::*;

   typedef struct {
      logic                req_type;
      logic [TYPE_W-1:0]   mem_type;
      logic [ADDR_W-1:0]   range_start;
      logic [ADDR_W-1:0]   range_end;
      logic [ATTR_W-1:0]   attributes;
   } map_request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                has_entry;
      logic [INDEX_W-1:0]  entry_index;
      logic [TYPE_W-1:0]   entry_type;
      logic [PAGE_W-1:0]   entry_start_page;
      logic [CNT_W-1:0]    entry_page_count;
      logic [ATTR_W-1:0]   entry_attr;
      logic                last;
   } map_entry_type;
endpackage

// ----- test/memory_range_map_insert_tb.sv -----
// Testbench for memory_range_map_insert: drives insert/clear requests, predicts the
// region table after each one and checks the dumped table entry by entry.
// Depends on mrmi_pkg, mrmi_if, mrmi_tb_pkg and the block itself.
module memory_range_map_insert_tb;
   import mrmi_pkg::*;
   import mrmi_tb_pkg::*;

   localparam int MAXN       = 64;
   localparam int PSHIFT     = 12;
   localparam int CYCLE_CAP  = 2000000;

   typedef struct {
      logic [TYPE_W-1:0] mtype;
      logic [63:0]       start_pg;
      logic [63:0]       npages;
      logic [ATTR_W-1:0] attr;
   } tb_region_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrmi_req_if req_chan ();
   mrmi_rsp_if rsp_chan ();

   memory_range_map_insert dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   tb_region_type map_table[$];
   map_entry_type dump_queue[$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("memory_range_map_insert_tb: FAIL");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
      $display("mismatch %s: got %0h expected %0h", what, got, exp);
      error_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // table update for one request; puts the status into each queued dump entry
   task automatic predict_map(input map_request_type r);
      tb_region_type pieces[$];
      tb_region_type nr;
      logic [63:0] s, e, ds, de;
      logic [STATUS_W-1:0] st;
      int right_idx, pos;
      map_entry_type m;
      st = STATUS_OK;
      if (r.req_type == REQ_CLEAR) begin
         map_table.delete();
      end else if (r.range_start >= r.range_end) begin
         st = STATUS_EMPTY;
      end else begin
         s = r.range_start >> PSHIFT;
         e = (r.range_end >> PSHIFT) + ((r.range_end[PSHIFT-1:0] != 0) ? 64'd1 : 64'd0);
         right_idx = -1;
         foreach (map_table[i]) begin
            ds = map_table[i].start_pg;
            de = ds + map_table[i].npages;
            if (de <= s || ds >= e) begin
               pieces.push_back(map_table[i]);
            end else begin
               if (ds < s) begin
                  nr = map_table[i]; nr.npages = s - ds; pieces.push_back(nr);
               end
               if (de > e) begin
                  right_idx = pieces.size();
                  nr = map_table[i]; nr.start_pg = e; nr.npages = de - e;
                  pieces.push_back(nr);
               end
            end
         end
         if (pieces.size() > MAXN && right_idx >= 0) begin
            pieces.delete(right_idx);
            st = STATUS_FULL;
         end
         if (pieces.size() < MAXN) begin
            pos = 0;
            while (pos < pieces.size() && pieces[pos].start_pg < s) pos++;
            nr.mtype = r.mem_type; nr.start_pg = s; nr.npages = e - s; nr.attr = r.attributes;
            pieces.insert(pos, nr);
         end else begin
            st = STATUS_FULL;
         end
         while (pieces.size() > MAXN) pieces.pop_back();
         map_table = pieces;
      end
      if (map_table.size() == 0) begin
         m = '{st, 1'b0, '0, '0, '0, '0, '0, 1'b1};
         dump_queue.push_back(m);
      end else begin
         foreach (map_table[i]) begin
            m.status = st; m.has_entry = 1'b1; m.entry_index = INDEX_W'(i);
            m.entry_type = map_table[i].mtype;
            m.entry_start_page = map_table[i].start_pg[PAGE_W-1:0];
            m.entry_page_count = map_table[i].npages[CNT_W-1:0];
            m.entry_attr = map_table[i].attr;
            m.last = (i == map_table.size() - 1);
            dump_queue.push_back(m);
         end
      end
   endtask

   task automatic send_request(input map_request_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= r.req_type;
      req_chan.mem_type    <= r.mem_type;
      req_chan.range_start <= r.range_start;
      req_chan.range_end   <= r.range_end;
      req_chan.attributes  <= r.attributes;
      predict_map(r);
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      // the next request is driven no earlier than the following falling edge
      @(negedge clock);
   endtask

   task automatic send_insert(input logic [3:0] t, input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] at);
      map_request_type r;
      r = '{REQ_INSERT, t, a, b, at};
      send_request(r);
   endtask

   task automatic send_clear();
      map_request_type r;
      r = '{REQ_CLEAR, TYPE_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, '0};
      send_request(r);
   endtask

   task automatic wait_drained();
      while (dump_queue.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      map_entry_type x;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (dump_queue.size() == 0) begin
            report("unexpected response", 64'(rsp_chan.entry_index), 64'd0);
         end else begin
            x = dump_queue.pop_front();
            if (rsp_chan.status !== x.status)
               report("status", 64'(rsp_chan.status), 64'(x.status));
            if (rsp_chan.has_entry !== x.has_entry)
               report("has_entry", 64'(rsp_chan.has_entry), 64'(x.has_entry));
            if (rsp_chan.entry_index !== x.entry_index)
               report("entry_index", 64'(rsp_chan.entry_index), 64'(x.entry_index));
            if (rsp_chan.entry_type !== x.entry_type)
               report("entry_type", 64'(rsp_chan.entry_type), 64'(x.entry_type));
            if (rsp_chan.entry_start_page !== x.entry_start_page)
               report("entry_start_page", 64'(rsp_chan.entry_start_page),
                      64'(x.entry_start_page));
            if (rsp_chan.entry_page_count !== x.entry_page_count)
               report("entry_page_count", 64'(rsp_chan.entry_page_count),
                      64'(x.entry_page_count));
            if (rsp_chan.entry_attr !== x.entry_attr)
               report("entry_attr", rsp_chan.entry_attr, x.entry_attr);
            if (rsp_chan.last !== x.last) report("last", 64'(rsp_chan.last), 64'(x.last));
         end
      end
   end

   // edge values, empty and inverted ranges, splits, top of memory
   task automatic test_directed();
      send_insert(4'h0, 64'h0, 64'h0, 64'h0);
      send_insert(4'h1, 64'h5000, 64'h4000, '1);
      send_insert(4'hF, 64'h1000, 64'h9001, 64'hFFFF_FFFF_FFFF_FFFF);
      send_insert(4'h2, 64'h3FFF, 64'h5000, 64'h1234);
      send_insert(4'h3, 64'h0, 64'h2000, 64'h8000_0000_0000_0001);
      send_insert(4'h4, 64'h8000, 64'hC000, 64'h55);
      send_insert(4'h5, 64'h0, 64'hF000, 64'hAA);
      send_insert(4'h6, 64'hFFFF_FFFF_FFFF_F000, '1, 64'h1);
      send_insert(4'h7, 64'h0, '1, 64'h2);
      send_insert(4'hA, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, rand64());
      send_clear();
      send_insert(4'h9, 64'h1000, 64'h1000, 64'h9);
      send_clear();
   endtask

   // fill the table with three-page entries, then split one to drop a right piece
   task automatic test_table_full();
      for (int i = 0; i < MAXN + 2; i++)
         send_insert(TYPE_W'($urandom), 64'(i * 4) << PSHIFT, 64'((i * 4) + 3) << PSHIFT,
                     rand64());
      send_insert(4'h3, 64'h1000, 64'h1800, 64'h77);
      send_insert(4'h4, 64'h40, 64'h80, 64'h66);
      send_insert(4'h5, 64'h0, 64'h7F000, 64'h44);
      wait_drained();
      send_clear();
   endtask

   task automatic test_random(input int n);
      logic [63:0] a, b;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: send_clear();
            1: send_insert(TYPE_W'($urandom), rand64(), rand64(), rand64());
            default: begin
               a = 64'($urandom_range(200)) << $urandom_range(PSHIFT - 4, PSHIFT);
               b = a + (64'($urandom_range(40)) << $urandom_range(8, PSHIFT));
               if ($urandom_range(9) == 0) begin
                  a = a ^ {1'($urandom_range(1)), 63'h0};
                  b = b ^ {1'($urandom_range(1)), 63'h0};
               end
               send_insert(TYPE_W'($urandom), a, b, rand64());
            end
         endcase
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_INSERT;
      req_chan.mem_type = '0;
      req_chan.range_start = '0;
      req_chan.range_end = '0;
      req_chan.attributes = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random(6);
      send_idle_pct = 80; test_random(6);
      send_idle_pct = 0; recv_stall_pct = 80; test_random(6);
      wait_drained();
      send_idle_pct = 16; recv_stall_pct = 16; test_random(6);
      wait_drained();
      repeat (100) @(negedge clock);
      if (error_count == 0 && dump_queue.size() == 0) begin
         $display("memory_range_map_insert_tb: PASS");
      end else begin
         $display("memory_range_map_insert_tb: FAIL");
      end
      $finish;
   end
endmodule

// ----- memory_range_map_insert.f -----
sv/mrmi_pkg.sv
sv/mrmi_if.sv
sv/mrmi_ram.sv
sv/mrmi_ctrl.sv
sv/mrmi_dp.sv
sv/memory_range_map_insert.sv
test/mrmi_tb_if.sv
test/memory_range_map_insert_tb.sv
